### rtl/core/bptc_pkg.sv
package bptc_pkg;

    // Field and configuration widths.
    localparam int RAW_W      = 24;
    localparam int OUT_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int OSR_W      = 3;

    // Pipeline depth: three stages for the sample scaling and six for the polynomial.
    localparam int SCALE_STAGES = 3;
    localparam int POLY_STAGES  = 6;
    localparam int NUM_STAGES   = SCALE_STAGES + POLY_STAGES;

    // Scaling datapath widths.
    // The shifted and biased sample stays inside [-2^30, 2^30 - 1].
    localparam int U_W     = 31;
    localparam int V_W     = 30;
    localparam int RECIP_W = 31;
    localparam int PROD_W  = V_W + RECIP_W;
    localparam int Q_W     = 26;
    localparam int SC_W    = Q_W + 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_COEFFS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_OFFSET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_LINEAR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_CROSS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIXED_CROSS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_ORDER      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_OSR       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_OSR        = 3'd7;

    // Pre-shift of the raw sample: the scale factor is m * 2^19 for the four low
    // codes and m * 2^13 for the four high codes, with m = 2^(code+1) - 1.
    localparam logic [2:0] PRE_SHIFT_LOW  = 3'd1;
    localparam logic [2:0] PRE_SHIFT_HIGH = 3'd7;

    // Reciprocals ceil(2^(30+l) / m) with l = ceil(log2(m)), exact for 30-bit dividends.
    localparam logic [RECIP_W-1:0] OSR_RECIP [8] = '{
        31'd1073741824, 31'd1431655766, 31'd1227133514, 31'd1145324613,
        31'd1108378658, 31'd1090785346, 31'd1082196485, 31'd1077952577
    };

    // Decoded calibration coefficients.
    typedef struct packed {
        logic signed [11:0] c0;
        logic signed [11:0] c1;
        logic signed [19:0] c00;
        logic signed [19:0] c10;
        logic signed [15:0] c01;
        logic signed [15:0] c11;
        logic signed [15:0] c20;
        logic signed [15:0] c21;
        logic signed [15:0] c30;
        logic [OSR_W-1:0]   press_osr;
        logic [OSR_W-1:0]   temp_osr;
    } t_coeffs;

    typedef logic [NUM_STAGES-1:0] t_stage_en;

    // Left shift that turns rawX * 2^20 / 2^s into an integer.
    function automatic logic [2:0] osr_pre_shift(input logic [OSR_W-1:0] code);
        return code[2] ? PRE_SHIFT_HIGH : PRE_SHIFT_LOW;
    endfunction

    // Rounding bias floor(m / 2) = 2^code - 1.
    function automatic logic [6:0] osr_bias(input logic [OSR_W-1:0] code);
        return 7'((8'd1 << code) - 8'd1);
    endfunction

    // Right shift after the reciprocal multiply: 30 + l.
    function automatic logic [5:0] osr_post_shift(input logic [OSR_W-1:0] code);
        return (code == 3'd0) ? 6'd30 : (6'd31 + 6'(code));
    endfunction

endpackage

### rtl/core/bptc_cfg_regs.sv
module bptc_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bptc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bptc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output bptc_pkg::t_coeffs                 o_coef
);
    import bptc_pkg::*;

    logic [23:0]      r_temp_coeffs;
    logic [19:0]      r_pressure_offset;
    logic [19:0]      r_pressure_linear;
    logic [15:0]      r_temp_cross;
    logic [15:0]      r_mixed_cross;
    logic [47:0]      r_high_order;
    logic [OSR_W-1:0] r_press_osr;
    logic [OSR_W-1:0] r_temp_osr;

    // Register writes; bits above each register's width are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_coeffs     <= '0;
            r_pressure_offset <= '0;
            r_pressure_linear <= '0;
            r_temp_cross      <= '0;
            r_mixed_cross     <= '0;
            r_high_order      <= '0;
            r_press_osr       <= '0;
            r_temp_osr        <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_TEMP_COEFFS:     r_temp_coeffs     <= i_cfg_data[23:0];
                REG_PRESSURE_OFFSET: r_pressure_offset <= i_cfg_data[19:0];
                REG_PRESSURE_LINEAR: r_pressure_linear <= i_cfg_data[19:0];
                REG_TEMP_CROSS:      r_temp_cross      <= i_cfg_data[15:0];
                REG_MIXED_CROSS:     r_mixed_cross     <= i_cfg_data[15:0];
                REG_HIGH_ORDER:      r_high_order      <= i_cfg_data[47:0];
                REG_PRESS_OSR:       r_press_osr       <= i_cfg_data[OSR_W-1:0];
                REG_TEMP_OSR:        r_temp_osr        <= i_cfg_data[OSR_W-1:0];
            endcase
        end
    end

    // Unpack the coefficient fields.
    always_comb begin
        o_coef.c0        = $signed(r_temp_coeffs[23:12]);
        o_coef.c1        = $signed(r_temp_coeffs[11:0]);
        o_coef.c00       = $signed(r_pressure_offset);
        o_coef.c10       = $signed(r_pressure_linear);
        o_coef.c01       = $signed(r_temp_cross);
        o_coef.c11       = $signed(r_mixed_cross);
        o_coef.c20       = $signed(r_high_order[47:32]);
        o_coef.c21       = $signed(r_high_order[31:16]);
        o_coef.c30       = $signed(r_high_order[15:0]);
        o_coef.press_osr = r_press_osr;
        o_coef.temp_osr  = r_temp_osr;
    end

endmodule

### rtl/core/bptc_pipe_ctrl.sv
module bptc_pipe_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_out_stall,
    output bptc_pkg::t_stage_en   o_en,
    output logic                  o_out_valid
);
    import bptc_pkg::*;

    logic [NUM_STAGES-1:0] r_valid;
    logic [NUM_STAGES-1:0] n_valid;
    t_stage_en             w_en;

    // A stage loads when it is empty or when the stage after it moves on,
    // so bubbles are squeezed out while the output waits.
    always_comb begin
        w_en[NUM_STAGES-1] = !r_valid[NUM_STAGES-1] || !i_out_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_valid[k] || w_en[k+1];
        end
        n_valid[0] = i_in_valid;
        for (int k = 1; k < NUM_STAGES; k++) begin
            n_valid[k] = r_valid[k-1];
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int k = 0; k < NUM_STAGES; k++) begin
                if (w_en[k]) begin
                    r_valid[k] <= n_valid[k];
                end
            end
        end
    end

    assign o_en        = w_en;
    assign o_out_valid = r_valid[NUM_STAGES-1];

endmodule

### rtl/core/bptc_scale.sv
module bptc_scale (
    input  logic                                  i_clk,
    input  logic [bptc_pkg::SCALE_STAGES-1:0]     i_en,
    input  logic [bptc_pkg::OSR_W-1:0]            i_osr_code,
    input  logic signed [bptc_pkg::RAW_W-1:0]     i_raw,
    output logic signed [bptc_pkg::SC_W-1:0]      o_scaled
);
    import bptc_pkg::*;

    // The scaled sample is floor(u / m) with u = raw * 2^(20-s) + floor(m/2).
    // Negative u is folded as ~floor(~u / m), so the divider sees only
    // non-negative values and uses an exact reciprocal multiply.

    logic signed [U_W-1:0]  w_raw_ext;
    logic signed [U_W-1:0]  w_u;
    logic                   n_neg;
    logic [V_W-1:0]         n_v;
    logic                   r_neg_a;
    logic [V_W-1:0]         r_v;
    logic [PROD_W-1:0]      n_prod;
    logic                   r_neg_b;
    logic [PROD_W-1:0]      r_prod;
    logic [PROD_W-1:0]      w_quo_full;
    logic [Q_W-1:0]         w_quo;
    logic signed [SC_W-1:0] n_scaled;
    logic signed [SC_W-1:0] r_scaled;

    // Stage 1: shift, add the rounding bias and fold the sign.
    always_comb begin
        w_raw_ext = U_W'(i_raw);
        w_u       = (w_raw_ext <<< osr_pre_shift(i_osr_code))
                    + $signed(U_W'(osr_bias(i_osr_code)));
        n_neg     = w_u[U_W-1];
        n_v       = n_neg ? ~w_u[V_W-1:0] : w_u[V_W-1:0];
    end

    // Stage 2: multiply by the reciprocal of the odd factor.
    assign n_prod = PROD_W'(r_v) * PROD_W'(OSR_RECIP[i_osr_code]);

    // Stage 3: drop the fraction and restore the sign.
    always_comb begin
        w_quo_full = r_prod >> osr_post_shift(i_osr_code);
        w_quo      = w_quo_full[Q_W-1:0];
        n_scaled   = r_neg_b ? $signed(~{1'b0, w_quo}) : $signed({1'b0, w_quo});
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_neg_a <= n_neg;
            r_v     <= n_v;
        end
        if (i_en[1]) begin
            r_neg_b <= r_neg_a;
            r_prod  <= n_prod;
        end
        if (i_en[2]) begin
            r_scaled <= n_scaled;
        end
    end

    assign o_scaled = r_scaled;

endmodule

### rtl/core/bptc_poly.sv
module bptc_poly (
    input  logic                                  i_clk,
    input  logic [bptc_pkg::POLY_STAGES-1:0]      i_en,
    input  bptc_pkg::t_coeffs                     i_coef,
    input  logic signed [bptc_pkg::SC_W-1:0]      i_tsc,
    input  logic signed [bptc_pkg::SC_W-1:0]      i_psc,
    output logic signed [bptc_pkg::OUT_W-1:0]     o_comp_temp,
    output logic signed [bptc_pkg::OUT_W-1:0]     o_comp_press
);
    import bptc_pkg::*;

    // Stage 1 products.
    logic signed [38:0]     n_m_tc1,  r_m_tc1;
    logic signed [42:0]     n_m_pc30, r_m_pc30;
    logic signed [42:0]     n_m_pc21, r_m_pc21;
    logic signed [53:0]     n_m_tp,   r_m_tp;
    logic signed [42:0]     n_m_tc01, r_m_tc01;
    logic signed [SC_W-1:0] r_psc1;

    // Stage 2 sums.
    logic signed [43:0]      w_tc1_rnd, w_pc30_rnd, w_pc21_rnd, w_tc01_rnd;
    logic signed [54:0]      w_tp_rnd;
    logic signed [OUT_W-1:0] n_temp, r_temp2;
    logic signed [29:0]      n_a, r_a;
    logic signed [29:0]      n_d, r_d;
    logic signed [31:0]      n_e, r_e;
    logic signed [29:0]      n_t01, r_t01_2;
    logic signed [SC_W-1:0]  r_psc2;

    // Stage 3 products.
    logic signed [56:0]      n_m_pa, r_m_pa;
    logic signed [61:0]      n_m_ed, r_m_ed;
    logic signed [SC_W-1:0]  r_psc3;
    logic signed [OUT_W-1:0] r_temp3;
    logic signed [29:0]      r_t01_3;

    // Stage 4 sums.
    logic signed [57:0]      w_pa_rnd;
    logic signed [62:0]      w_ed_rnd;
    logic signed [34:0]      n_b, r_b;
    logic signed [39:0]      n_ed, r_ed;
    logic signed [SC_W-1:0]  r_psc4;
    logic signed [OUT_W-1:0] r_temp4;
    logic signed [29:0]      r_t01_4;

    // Stage 5 products and the remaining pressure terms.
    logic signed [41:0]      n_m_pbh, r_m_pbh;
    logic signed [47:0]      n_m_pbl, r_m_pbl;
    logic signed [41:0]      n_rest, r_rest;
    logic signed [OUT_W-1:0] r_temp5;

    // Stage 6 final sum and clamp.
    logic signed [48:0]      w_pbl_rnd;
    logic signed [44:0]      w_press;
    logic                    w_press_fits;
    logic signed [OUT_W-1:0] n_press;
    logic signed [OUT_W-1:0] r_comp_temp, r_comp_press;

    // Stage 1: every product that needs only the scaled samples.
    always_comb begin
        n_m_tc1  = i_coef.c1 * i_tsc;
        n_m_pc30 = i_psc * i_coef.c30;
        n_m_pc21 = i_psc * i_coef.c21;
        n_m_tp   = i_tsc * i_psc;
        n_m_tc01 = i_tsc * i_coef.c01;
    end

    // Stage 2: round the products and add the constant terms.
    always_comb begin
        w_tc1_rnd  = (44'(r_m_tc1)  + 44'sd2048) >>> 12;
        w_pc30_rnd = (44'(r_m_pc30) + 44'sd2048) >>> 12;
        w_pc21_rnd = (44'(r_m_pc21) + 44'sd2048) >>> 12;
        w_tc01_rnd = (44'(r_m_tc01) + 44'sd2048) >>> 12;
        w_tp_rnd   = (55'(r_m_tp)   + 55'sd524288) >>> 20;
        // The temperature stays well inside 32 bits for every input.
        n_temp     = (OUT_W'(i_coef.c0) <<< 7) + OUT_W'(w_tc1_rnd);
        n_a        = (30'(i_coef.c20) <<< 8) + 30'(w_pc30_rnd);
        n_d        = (30'(i_coef.c11) <<< 8) + 30'(w_pc21_rnd);
        n_e        = 32'(w_tp_rnd);
        n_t01      = 30'(w_tc01_rnd);
    end

    // Stage 3: second level of the Horner chain and the cross term.
    always_comb begin
        n_m_pa = r_psc2 * r_a;
        n_m_ed = r_e * r_d;
    end

    // Stage 4: b = c10 + Psc * a, and round the cross term.
    always_comb begin
        w_pa_rnd = (58'(r_m_pa) + 58'sd524288) >>> 20;
        w_ed_rnd = (63'(r_m_ed) + 63'sd524288) >>> 20;
        n_b      = (35'(i_coef.c10) <<< 8) + 35'(w_pa_rnd);
        n_ed     = 40'(w_ed_rnd);
    end

    // Stage 5: Psc * b as two partial products split at bit 20, so the
    // rounding applies to the low part only. The other terms are summed here.
    always_comb begin
        n_m_pbh = r_psc4 * $signed(r_b[34:20]);
        n_m_pbl = r_psc4 * $signed({1'b0, r_b[19:0]});
        n_rest  = (42'(i_coef.c00) <<< 8) + 42'(r_t01_4) + 42'(r_ed);
    end

    // Stage 6: final pressure sum with saturation to 32 bits.
    always_comb begin
        w_pbl_rnd    = (49'(r_m_pbl) + 49'sd524288) >>> 20;
        w_press      = 45'(r_m_pbh) + 45'(w_pbl_rnd) + 45'(r_rest);
        w_press_fits = (&w_press[44:OUT_W-1]) || !(|w_press[44:OUT_W-1]);
        if (w_press_fits) begin
            n_press = w_press[OUT_W-1:0];
        end else if (w_press[44]) begin
            n_press = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            n_press = {1'b0, {(OUT_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_m_tc1  <= n_m_tc1;
            r_m_pc30 <= n_m_pc30;
            r_m_pc21 <= n_m_pc21;
            r_m_tp   <= n_m_tp;
            r_m_tc01 <= n_m_tc01;
            r_psc1   <= i_psc;
        end
        if (i_en[1]) begin
            r_temp2 <= n_temp;
            r_a     <= n_a;
            r_d     <= n_d;
            r_e     <= n_e;
            r_t01_2 <= n_t01;
            r_psc2  <= r_psc1;
        end
        if (i_en[2]) begin
            r_m_pa  <= n_m_pa;
            r_m_ed  <= n_m_ed;
            r_psc3  <= r_psc2;
            r_temp3 <= r_temp2;
            r_t01_3 <= r_t01_2;
        end
        if (i_en[3]) begin
            r_b     <= n_b;
            r_ed    <= n_ed;
            r_psc4  <= r_psc3;
            r_temp4 <= r_temp3;
            r_t01_4 <= r_t01_3;
        end
        if (i_en[4]) begin
            r_m_pbh <= n_m_pbh;
            r_m_pbl <= n_m_pbl;
            r_rest  <= n_rest;
            r_temp5 <= r_temp4;
        end
        if (i_en[5]) begin
            r_comp_temp  <= r_temp5;
            r_comp_press <= n_press;
        end
    end

    assign o_comp_temp  = r_comp_temp;
    assign o_comp_press = r_comp_press;

endmodule

### rtl/core/baro_pressure_temp_compensation.sv
// Nine register stages: three scale, six polynomial, the last being the output register.
// Throughput: one item per cycle while o_in_stall is low;
// the widest multiply in any one stage is 32x30 bits.
// A stage takes a new item whenever it is empty, so bubbles close up while the output stalls.
// Reset (synchronous, active low) empties the pipeline and clears all calibration registers.
module baro_pressure_temp_compensation (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [bptc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [bptc_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [bptc_pkg::RAW_W-1:0]     i_raw_temp,
    input  logic signed [bptc_pkg::RAW_W-1:0]     i_raw_press,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [bptc_pkg::OUT_W-1:0]     o_comp_temp,
    output logic signed [bptc_pkg::OUT_W-1:0]     o_comp_press
);
    import bptc_pkg::*;

    t_coeffs                w_coef;
    t_stage_en              w_en;
    logic signed [SC_W-1:0] w_tsc;
    logic signed [SC_W-1:0] w_psc;

    // Calibration registers.
    bptc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_coef      (w_coef)
    );

    // Stage valid bits and load enables.
    bptc_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_en        (w_en),
        .o_out_valid (o_out_valid)
    );

    assign o_in_stall = !w_en[0];

    // Temperature and pressure sample scaling.
    bptc_scale u_scale_temp (
        .i_clk      (i_clk),
        .i_en       (w_en[SCALE_STAGES-1:0]),
        .i_osr_code (w_coef.temp_osr),
        .i_raw      (i_raw_temp),
        .o_scaled   (w_tsc)
    );

    bptc_scale u_scale_press (
        .i_clk      (i_clk),
        .i_en       (w_en[SCALE_STAGES-1:0]),
        .i_osr_code (w_coef.press_osr),
        .i_raw      (i_raw_press),
        .o_scaled   (w_psc)
    );

    // Compensation polynomials.
    bptc_poly u_poly (
        .i_clk        (i_clk),
        .i_en         (w_en[NUM_STAGES-1:SCALE_STAGES]),
        .i_coef       (w_coef),
        .i_tsc        (w_tsc),
        .i_psc        (w_psc),
        .o_comp_temp  (o_comp_temp),
        .o_comp_press (o_comp_press)
    );

endmodule
